/* hdl/mmb_pkg.sv */
// Shared types and constants for the model matrix builder.
// No dependencies; used by every module of the block.
package mmb_pkg;

   // 1.0 in the Q.28 format of the rotation entries
   localparam logic signed [33:0] ROT_ONE = 34'sd268435456;
   // half an output LSB in the Q.44 product, for round to nearest
   localparam logic signed [59:0] RND_HALF = 60'sd134217728;
   localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
   localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [23:0] scale_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [23:0] right_x;
      logic signed [23:0] right_y;
      logic signed [23:0] right_z;
      logic signed [23:0] up_x;
      logic signed [23:0] up_y;
      logic signed [23:0] up_z;
      logic signed [23:0] fwd_x;
      logic signed [23:0] fwd_y;
      logic signed [23:0] fwd_z;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_type;

   // Quaternion products, Q4.28
   typedef struct packed {
      logic signed [31:0] xx;
      logic signed [31:0] yy;
      logic signed [31:0] zz;
      logic signed [31:0] xy;
      logic signed [31:0] xz;
      logic signed [31:0] yz;
      logic signed [31:0] wx;
      logic signed [31:0] wy;
      logic signed [31:0] wz;
   } prod_type;

   // Rotation entries (Q.28, column major), column scales and position
   typedef struct packed {
      logic [8:0][33:0] ent;
      logic [2:0][24:0] scl;
      logic [2:0][31:0] pos;
   } rot_type;

endpackage

/* hdl/model_matrix_builder_top.sv */
// Channel  Dir  Handshake               Payload
// req      in   req_valid / req_ready   mmb_pkg::req_type  (transform)
// rsp      out  rsp_valid / rsp_ready   mmb_pkg::rsp_type  (model matrix)
//
// Four register stages: products, rotation entries, split scale multiply,
// round/saturate into the output register. One item per cycle when rsp
// moves. Each stage loads when it is empty or the stage after it moves, so
// bubbles close up and a stalled rsp holds the pipe without losing items.
// Synchronous active-high reset clears the valid bits only.
// Depends on mmb_pkg, mmb_rot, mmb_scale.
module model_matrix_builder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mmb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mmb_pkg::rsp_type rsp_data
);

   logic             rot_valid;
   logic             rot_ready;
   mmb_pkg::rot_type rot_data;

   mmb_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_data  (rot_data)
   );

   mmb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

/* hdl/mmb_rot.sv */
// Quaternion products and rotation entries: two pipeline stages.
// Depends on mmb_pkg.
module mmb_rot (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mmb_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mmb_pkg::rot_type out_data
);

   logic              a_vld_ff;
   mmb_pkg::prod_type a_prod_ff;
   mmb_pkg::prod_type a_prod_in;
   logic [2:0][24:0]  a_scl_ff;
   logic [2:0][24:0]  a_scl_in;
   logic [2:0][31:0]  a_pos_ff;

   logic              b_vld_ff;
   mmb_pkg::rot_type  b_data_ff;
   mmb_pkg::rot_type  b_data_in;

   logic              en_a;
   logic              en_b;

   function automatic logic signed [33:0] twice(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic sub);
      logic signed [33:0] s;
      begin
         s = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
         twice = s <<< 1;
      end
   endfunction

   assign en_b     = !b_vld_ff || out_ready;
   assign en_a     = !a_vld_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      a_prod_in.xx = in_data.quat_x * in_data.quat_x;
      a_prod_in.yy = in_data.quat_y * in_data.quat_y;
      a_prod_in.zz = in_data.quat_z * in_data.quat_z;
      a_prod_in.xy = in_data.quat_x * in_data.quat_y;
      a_prod_in.xz = in_data.quat_x * in_data.quat_z;
      a_prod_in.yz = in_data.quat_y * in_data.quat_z;
      a_prod_in.wx = in_data.quat_w * in_data.quat_x;
      a_prod_in.wy = in_data.quat_w * in_data.quat_y;
      a_prod_in.wz = in_data.quat_w * in_data.quat_z;
      // x scale negated here; 25 bits so the most negative value stays exact
      a_scl_in[0]  = -25'(in_data.scale_x);
      a_scl_in[1]  = 25'(in_data.scale_y);
      a_scl_in[2]  = 25'(in_data.scale_z);
   end

   always_comb begin
      b_data_in.ent[0] = mmb_pkg::ROT_ONE - twice(a_prod_ff.yy, a_prod_ff.zz, 1'b0);
      b_data_in.ent[1] = twice(a_prod_ff.xy, a_prod_ff.wz, 1'b0);
      b_data_in.ent[2] = twice(a_prod_ff.xz, a_prod_ff.wy, 1'b1);
      b_data_in.ent[3] = twice(a_prod_ff.xy, a_prod_ff.wz, 1'b1);
      b_data_in.ent[4] = mmb_pkg::ROT_ONE - twice(a_prod_ff.xx, a_prod_ff.zz, 1'b0);
      b_data_in.ent[5] = twice(a_prod_ff.yz, a_prod_ff.wx, 1'b0);
      b_data_in.ent[6] = twice(a_prod_ff.xz, a_prod_ff.wy, 1'b0);
      b_data_in.ent[7] = twice(a_prod_ff.yz, a_prod_ff.wx, 1'b1);
      b_data_in.ent[8] = mmb_pkg::ROT_ONE - twice(a_prod_ff.xx, a_prod_ff.yy, 1'b0);
      b_data_in.scl    = a_scl_ff;
      b_data_in.pos    = a_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_vld_ff <= in_valid;
         end
         if (en_b) begin
            b_vld_ff <= a_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_prod_ff <= a_prod_in;
         a_scl_ff  <= a_scl_in;
         a_pos_ff  <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
      end
      if (en_b) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_data  = b_data_ff;

endmodule

/* hdl/mmb_scale.sv */
// Column scaling: split 34x25 multiply, then round and saturate to Q8.16.
// Depends on mmb_pkg.
module mmb_scale (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mmb_pkg::rot_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mmb_pkg::rsp_type out_data
);

   logic               c_vld_ff;
   logic signed [42:0] c_lo_ff [9];
   logic signed [42:0] c_lo_in [9];
   logic signed [41:0] c_hi_ff [9];
   logic signed [41:0] c_hi_in [9];
   logic [2:0][31:0]   c_pos_ff;

   logic               d_vld_ff;
   logic signed [23:0] d_ent_ff [9];
   logic signed [23:0] d_ent_in [9];
   logic [2:0][31:0]   d_pos_ff;

   logic               en_c;
   logic               en_d;

   assign en_d     = !d_vld_ff || out_ready;
   assign en_c     = !c_vld_ff || en_d;
   assign in_ready = en_c;

   // entry = hi * 2^17 + lo, lo taken as unsigned 17 bits
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         c_lo_in[i] = $signed({1'b0, in_data.ent[i][16:0]}) * $signed(in_data.scl[i / 3]);
         c_hi_in[i] = $signed(in_data.ent[i][33:17]) * $signed(in_data.scl[i / 3]);
      end
   end

   always_comb begin
      logic signed [59:0] sum;
      logic signed [31:0] r;
      for (int i = 0; i < 9; i++) begin
         sum = (60'(c_hi_ff[i]) <<< 17) + 60'(c_lo_ff[i]) + mmb_pkg::RND_HALF;
         r   = $signed(sum[59:28]);
         if (r > mmb_pkg::OUT_MAX) begin
            d_ent_in[i] = mmb_pkg::OUT_MAX[23:0];
         end else if (r < mmb_pkg::OUT_MIN) begin
            d_ent_in[i] = mmb_pkg::OUT_MIN[23:0];
         end else begin
            d_ent_in[i] = r[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         if (en_c) begin
            c_vld_ff <= in_valid;
         end
         if (en_d) begin
            d_vld_ff <= c_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_lo_ff  <= c_lo_in;
         c_hi_ff  <= c_hi_in;
         c_pos_ff <= in_data.pos;
      end
      if (en_d) begin
         d_ent_ff <= d_ent_in;
         d_pos_ff <= c_pos_ff;
      end
   end

   assign out_valid        = d_vld_ff;
   assign out_data.right_x = d_ent_ff[0];
   assign out_data.right_y = d_ent_ff[1];
   assign out_data.right_z = d_ent_ff[2];
   assign out_data.up_x    = d_ent_ff[3];
   assign out_data.up_y    = d_ent_ff[4];
   assign out_data.up_z    = d_ent_ff[5];
   assign out_data.fwd_x   = d_ent_ff[6];
   assign out_data.fwd_y   = d_ent_ff[7];
   assign out_data.fwd_z   = d_ent_ff[8];
   assign out_data.trans_x = d_pos_ff[2];
   assign out_data.trans_y = d_pos_ff[1];
   assign out_data.trans_z = d_pos_ff[0];

endmodule

/* hdl/mmb_checker.sv */
// Port-level checks for the model matrix builder, bound to the top level.
// Depends on mmb_pkg.
module mmb_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mmb_pkg::rsp_type rsp_data
);

   // empty output register means every stage can move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with output empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed or dropped");

endmodule

bind model_matrix_builder_top mmb_port_checks u_mmb_port_checks (.*);

/* tb/mmb_checker.sv */
// Scoreboard for the model matrix builder: predicts each matrix from the
// accepted transform and compares it with the rsp channel. Depends on mmb_pkg.
module mmb_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  mmb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  mmb_pkg::rsp_type rsp_data,
   input  logic             end_check,
   output int               errors,
   output int               checked,
   output int               pending,
   output int               saturated
);
   timeunit 1ns;
   timeprecision 1ps;

   mmb_pkg::rsp_type matrix_q[$];
   bit               leftover_done;

   initial begin
      errors        = 0;
      checked       = 0;
      pending       = 0;
      saturated     = 0;
      leftover_done = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mmb_checker: %s", $realtime, what);
      errors++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Q.28 entry times Q8.16 scale, round half up to Q.16, clamp to 24 bits
   function automatic logic [23:0] scale_rot(input longint rot, input longint scl,
                                              inout int n_sat);
      longint p;
      p = (rot * scl + (64'sd1 <<< 27)) >>> 28;
      if (p > longint'(mmb_pkg::OUT_MAX)) begin
         p = mmb_pkg::OUT_MAX;
         n_sat++;
      end else if (p < longint'(mmb_pkg::OUT_MIN)) begin
         p = mmb_pkg::OUT_MIN;
         n_sat++;
      end
      return p[23:0];
   endfunction

   function automatic mmb_pkg::rsp_type build_matrix(input mmb_pkg::req_type t,
                                                     output int n_sat);
      longint w, x, y, z, sx, sy, sz, one;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      mmb_pkg::rsp_type m;
      n_sat = 0;
      one = longint'(mmb_pkg::ROT_ONE);
      w  = longint'(signed'(t.quat_w));
      x  = longint'(signed'(t.quat_x));
      y  = longint'(signed'(t.quat_y));
      z  = longint'(signed'(t.quat_z));
      // negation happens at full width, so -128.0 becomes +128.0
      sx = -longint'(signed'(t.scale_x));
      sy = longint'(signed'(t.scale_y));
      sz = longint'(signed'(t.scale_z));
      xx = x * x;  yy = y * y;  zz = z * z;
      xy = x * y;  xz = x * z;  yz = y * z;
      wx = w * x;  wy = w * y;  wz = w * z;
      m.right_x = scale_rot(one - 2 * (yy + zz), sx, n_sat);
      m.right_y = scale_rot(2 * (xy + wz), sx, n_sat);
      m.right_z = scale_rot(2 * (xz - wy), sx, n_sat);
      m.up_x    = scale_rot(2 * (xy - wz), sy, n_sat);
      m.up_y    = scale_rot(one - 2 * (xx + zz), sy, n_sat);
      m.up_z    = scale_rot(2 * (yz + wx), sy, n_sat);
      m.fwd_x   = scale_rot(2 * (xz + wy), sz, n_sat);
      m.fwd_y   = scale_rot(2 * (yz - wx), sz, n_sat);
      m.fwd_z   = scale_rot(one - 2 * (xx + yy), sz, n_sat);
      m.trans_x = t.pos_x;
      m.trans_y = t.pos_y;
      m.trans_z = t.pos_z;
      return m;
   endfunction

   always @(posedge clock) begin
      mmb_pkg::rsp_type want;
      int               n_sat;
      if (reset) begin
         matrix_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            want = build_matrix(req_data, n_sat);
            saturated += n_sat;
            matrix_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (matrix_q.size() == 0) begin
               report_mismatch("matrix item with no transform outstanding");
            end else begin
               want = matrix_q.pop_front();
               check_field("right_x", signed'(rsp_data.right_x), signed'(want.right_x));
               check_field("right_y", signed'(rsp_data.right_y), signed'(want.right_y));
               check_field("right_z", signed'(rsp_data.right_z), signed'(want.right_z));
               check_field("up_x", signed'(rsp_data.up_x), signed'(want.up_x));
               check_field("up_y", signed'(rsp_data.up_y), signed'(want.up_y));
               check_field("up_z", signed'(rsp_data.up_z), signed'(want.up_z));
               check_field("fwd_x", signed'(rsp_data.fwd_x), signed'(want.fwd_x));
               check_field("fwd_y", signed'(rsp_data.fwd_y), signed'(want.fwd_y));
               check_field("fwd_z", signed'(rsp_data.fwd_z), signed'(want.fwd_z));
               check_field("trans_x", signed'(rsp_data.trans_x), signed'(want.trans_x));
               check_field("trans_y", signed'(rsp_data.trans_y), signed'(want.trans_y));
               check_field("trans_z", signed'(rsp_data.trans_z), signed'(want.trans_z));
               checked++;
            end
         end
         if (end_check && !leftover_done) begin
            leftover_done = 1'b1;
            if (matrix_q.size() != 0)
               report_mismatch($sformatf("%0d matrices never came out", matrix_q.size()));
         end
      end
      pending = matrix_q.size();
   end

endmodule

/* tb/tb_model_matrix_builder_top.sv */
// Testbench top for model_matrix_builder_top: drives transforms and rsp
// back-pressure, gives the verdict. Depends on mmb_pkg and mmb_checker.
module tb_model_matrix_builder_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mmb_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mmb_pkg::rsp_type rsp_data;
   logic             end_check = 1'b0;
   logic             steady    = 1'b0;

   int errors, checked, pending, saturated;
   int sent     = 0;
   int directed = 0;

   model_matrix_builder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mmb_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .end_check (end_check),
      .errors    (errors),
      .checked   (checked),
      .pending   (pending),
      .saturated (saturated)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_model_matrix_builder_top: errors");
      $finish;
   end

   // sink back-pressure
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= steady || ($urandom_range(99) >= 19);
      end
   end

   function automatic mmb_pkg::req_type make_xf(input int w, input int x, input int y,
                                                input int z, input int sx, input int sy,
                                                input int sz, input int px, input int py,
                                                input int pz);
      mmb_pkg::req_type t;
      t.quat_w  = 16'(w);
      t.quat_x  = 16'(x);
      t.quat_y  = 16'(y);
      t.quat_z  = 16'(z);
      t.scale_x = 24'(sx);
      t.scale_y = 24'(sy);
      t.scale_z = 24'(sz);
      t.pos_x   = px;
      t.pos_y   = py;
      t.pos_z   = pz;
      return t;
   endfunction

   function automatic logic [15:0] corner_quat();
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'h4000;
         4:       return 16'hc000;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [23:0] corner_scale();
      case ($urandom_range(5))
         0:       return 24'h800000;
         1:       return 24'h7fffff;
         2:       return 24'h000000;
         3:       return 24'h010000;
         4:       return 24'hff0000;
         default: return 24'h000001;
      endcase
   endfunction

   function automatic mmb_pkg::req_type random_transform();
      mmb_pkg::req_type t;
      int               kind;
      kind    = $urandom_range(9);
      t.pos_x = $urandom();
      t.pos_y = $urandom();
      t.pos_z = $urandom();
      if (kind < 4) begin
         t.quat_w  = 16'($urandom());
         t.quat_x  = 16'($urandom());
         t.quat_y  = 16'($urandom());
         t.quat_z  = 16'($urandom());
         t.scale_x = 24'($urandom());
         t.scale_y = 24'($urandom());
         t.scale_z = 24'($urandom());
      end else if (kind < 9) begin
         // quaternion components within +/-1.0 and scales within +/-16
         t.quat_w  = 16'($urandom_range(32768) - 16384);
         t.quat_x  = 16'($urandom_range(32768) - 16384);
         t.quat_y  = 16'($urandom_range(32768) - 16384);
         t.quat_z  = 16'($urandom_range(32768) - 16384);
         t.scale_x = 24'($urandom_range(2097152) - 1048576);
         t.scale_y = 24'($urandom_range(2097152) - 1048576);
         t.scale_z = 24'($urandom_range(2097152) - 1048576);
      end else begin
         t.quat_w  = corner_quat();
         t.quat_x  = corner_quat();
         t.quat_y  = corner_quat();
         t.quat_z  = corner_quat();
         t.scale_x = corner_scale();
         t.scale_y = corner_scale();
         t.scale_z = corner_scale();
      end
      return t;
   endfunction

   // called and returns at a falling edge
   task automatic send_item(input mmb_pkg::req_type t);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   initial begin
      mmb_pkg::req_type xf_list[$];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      xf_list.push_back(make_xf(16384, 0, 0, 0, 65536, 65536, 65536, 0, 0, 0));
      xf_list.push_back(make_xf(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      xf_list.push_back(make_xf(32767, 32767, 32767, 32767, 8388607, 8388607, 8388607,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      xf_list.push_back(make_xf(-32768, -32768, -32768, -32768, -8388608, -8388608,
                                -8388608, 32'h80000000, 32'h80000000, 32'h80000000));
      // most negative x scale negates to +128.0, then clamps
      xf_list.push_back(make_xf(16384, 0, 0, 0, -8388608, 65536, 65536, 1, -1, 65536));
      xf_list.push_back(make_xf(16384, 0, 0, 0, 8388607, -65536, 131072, -1, 1, 0));
      // exact half-LSB products: ties go up
      xf_list.push_back(make_xf(0, 4, 4, 0, -(1 << 22), 1 << 22, 1 << 22, 0, 0, 0));
      xf_list.push_back(make_xf(0, 4, 4, 0, 1 << 22, -(1 << 22), -(1 << 22), 0, 0, 0));
      // unit and non-unit quaternions, used as given
      xf_list.push_back(make_xf(32767, 0, 0, 0, 65536, 65536, 65536, 5, 6, 7));
      xf_list.push_back(make_xf(8000, 3000, -2000, 1000, 65536, 65536, 65536, 0, 0, 0));
      xf_list.push_back(make_xf(11585, 0, 0, 11585, 65536, 131072, 32768, 100, 200, 300));
      xf_list.push_back(make_xf(0, -16384, 0, 0, 196608, -65536, 65536, 0, 0, 0));
      xf_list.push_back(make_xf(-32768, 32767, 32767, 32767, 65536, 65536, 65536, 0, 0, 0));
      xf_list.push_back(make_xf(16384, 0, 0, 0, 1, 1, 1, 0, 0, 0));
      xf_list.push_back(make_xf(16384, 0, 0, 0, -1, -1, -1, 0, 0, 0));
      foreach (xf_list[i])
         send_item(xf_list[i]);
      directed = xf_list.size();

      for (int i = 0; i < 950; i++) begin
         if (i == 350)
            steady <= 1'b1;
         else if (i == 550)
            steady <= 1'b0;
         send_item(random_transform());
      end
      req_valid <= 1'b0;

      while (pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      end_check <= 1'b1;
      repeat (2) @(negedge clock);

      $display("%0d transforms sent (%0d directed), %0d matrices checked, %0d entries clamped",
               sent, directed, checked, saturated);
      if (errors == 0)
         $display("tb_model_matrix_builder_top: clean");
      else
         $display("tb_model_matrix_builder_top: errors");
      $finish;
   end

endmodule
